@@ sv/ttwrm_pkg.sv @@
// ----------------------------------------------------------------------------
// Tag time-window record matcher package
// Shared types and constants for the record matcher and its channels.
// ----------------------------------------------------------------------------
package ttwrm_pkg;

   localparam int RECORD_BYTES = 10;
   localparam int TAG_BYTES    = 5;
   localparam int BUF_BYTES    = RECORD_BYTES - 1;
   localparam int POS_W        = 4;
   localparam int TAG_W        = 8 * TAG_BYTES;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 40;
   localparam int HOUR_W       = 5;
   localparam int MINUTE_W     = 6;
   localparam int FLAG_CAPTURE_BIT = 4;

   localparam logic [7:0] CODE_MASK = 8'h0F;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_TAG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOW_HOUR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOW_MINUTE = 2'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      byte_type         start_hour;
      byte_type         start_minute;
      byte_type         end_hour;
      byte_type         end_minute;
   } record_type;

   typedef struct packed {
      logic     qualify;
      logic     capture;
      byte_type code;
   } verdict_type;

endpackage

@@ sv/ttwrm_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Carries one table byte and its end-of-table mark per request.
// ----------------------------------------------------------------------------
interface ttwrm_req_if;
   logic              valid;
   logic              ready;
   ttwrm_pkg::byte_type table_byte;
   logic              last_byte;

   modport source (output valid, output table_byte, output last_byte, input ready);
   modport sink   (input valid, input table_byte, input last_byte, output ready);
endinterface

@@ sv/ttwrm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Carries the capture flag and picture code at the end of a table.
// ----------------------------------------------------------------------------
interface ttwrm_rsp_if;
   logic              valid;
   logic              ready;
   logic              capture;
   ttwrm_pkg::byte_type picture_code;

   modport source (output valid, output capture, output picture_code, input ready);
   modport sink   (input valid, input capture, input picture_code, output ready);
endinterface

@@ sv/ttwrm_csr_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data per request.
// ----------------------------------------------------------------------------
interface ttwrm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ttwrm_pkg::CSR_IDX_W-1:0]     index;
   logic [ttwrm_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ttwrm_window_eval.sv @@
// ----------------------------------------------------------------------------
// Record window evaluator
// Checks tag and flags of a complete record and tests the current time
// against its window.
// ----------------------------------------------------------------------------
module ttwrm_window_eval (
   input  ttwrm_pkg::record_type             record,
   input  ttwrm_pkg::byte_type               flags,
   input  logic [ttwrm_pkg::TAG_W-1:0]       search_tag,
   input  logic [ttwrm_pkg::HOUR_W-1:0]      now_hour,
   input  logic [ttwrm_pkg::MINUTE_W-1:0]    now_minute,
   output ttwrm_pkg::verdict_type            verdict
);

   logic [15:0] start_t;
   logic [15:0] stop_t;
   logic [15:0] now_t;
   logic        forward;
   logic        fwd_hit;
   logic        wrap_hit;

   assign start_t = {record.start_hour, record.start_minute};
   assign stop_t  = {record.end_hour, record.end_minute};
   assign now_t   = {3'b000, now_hour, 2'b00, now_minute};
   assign forward = stop_t > start_t;
   assign fwd_hit = (stop_t > now_t) && (now_t > start_t);
   assign wrap_hit = ((stop_t > now_t) && (now_t < start_t)) ||
                     ((stop_t < now_t) && (now_t > start_t));

   always_comb begin
      verdict.qualify = (record.tag == search_tag) && flags[ttwrm_pkg::FLAG_CAPTURE_BIT];
      if (forward) begin
         verdict.capture = fwd_hit;
         verdict.code    = flags & ttwrm_pkg::CODE_MASK;
      end else begin
         verdict.capture = wrap_hit;
         verdict.code    = flags;
      end
   end

endmodule

@@ sv/tag_time_window_record_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Tag time-window record matcher
// Collects table bytes into records, evaluates each complete record against
// the search tag and current time, and reports the verdict at table end.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, also while one result waits to be taken.
// Result: when the result register is free, the result is valid in the cycle
// after the request marked last byte.
// A last-byte request stalls only while two results are held.
// Reset clears the byte position, verdict state, registers and result valids.
module tag_time_window_record_matcher_unit (
   input logic         clock,
   input logic         reset,
   ttwrm_req_if.sink   req,
   ttwrm_rsp_if.source rsp,
   ttwrm_csr_if.sink   csr
);

   ttwrm_pkg::byte_type                 rec_ff [ttwrm_pkg::BUF_BYTES];
   logic [ttwrm_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                                cap_ff, cap_in;
   ttwrm_pkg::byte_type                 held_ff, held_in;
   logic [ttwrm_pkg::TAG_W-1:0]         tag_ff;
   logic [ttwrm_pkg::HOUR_W-1:0]        hour_ff;
   logic [ttwrm_pkg::MINUTE_W-1:0]      minute_ff;
   logic                                out_valid_ff;
   logic                                out_cap_ff;
   ttwrm_pkg::byte_type                 out_code_ff;
   logic                                skid_valid_ff;
   logic                                skid_cap_ff;
   ttwrm_pkg::byte_type                 skid_code_ff;
   logic                                res_push;
   logic                                res_load;
   ttwrm_pkg::byte_type                 res_code;
   logic                                accept;
   logic                                at_flags;
   ttwrm_pkg::record_type               record;
   ttwrm_pkg::verdict_type              verdict;

   assign csr.ready = 1'b1;
   assign req.ready = !skid_valid_ff || !req.last_byte;
   assign accept    = req.valid && req.ready;
   assign at_flags  = pos_ff == ttwrm_pkg::LAST_POS;
   assign res_push  = accept && req.last_byte;
   assign res_load  = !out_valid_ff || rsp.ready;
   assign res_code  = cap_in ? held_in : '0;

   assign record.tag          = {rec_ff[0], rec_ff[1], rec_ff[2], rec_ff[3], rec_ff[4]};
   assign record.start_hour   = rec_ff[5];
   assign record.start_minute = rec_ff[6];
   assign record.end_hour     = rec_ff[7];
   assign record.end_minute   = rec_ff[8];

   ttwrm_window_eval u_eval (
      .record     (record),
      .flags      (req.table_byte),
      .search_tag (tag_ff),
      .now_hour   (hour_ff),
      .now_minute (minute_ff),
      .verdict    (verdict)
   );

   always_comb begin
      pos_in  = pos_ff;
      cap_in  = cap_ff;
      held_in = held_ff;
      if (at_flags) begin
         pos_in = '0;
         if (verdict.qualify) begin
            cap_in = verdict.capture;
            if (verdict.capture) begin
               held_in = verdict.code;
            end
         end
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !at_flags) begin
         rec_ff[pos_ff[ttwrm_pkg::POS_W-1:0]] <= req.table_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cap_ff  <= 1'b0;
         held_ff <= '0;
      end else if (accept) begin
         if (req.last_byte) begin
            pos_ff  <= '0;
            cap_ff  <= 1'b0;
            held_ff <= '0;
         end else begin
            pos_ff  <= pos_in;
            cap_ff  <= cap_in;
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (res_load) begin
         out_valid_ff  <= skid_valid_ff || res_push;
         skid_valid_ff <= skid_valid_ff && res_push;
      end else begin
         skid_valid_ff <= skid_valid_ff || res_push;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         if (skid_valid_ff) begin
            out_cap_ff  <= skid_cap_ff;
            out_code_ff <= skid_code_ff;
         end else if (res_push) begin
            out_cap_ff  <= cap_in;
            out_code_ff <= res_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_push && (skid_valid_ff || !res_load)) begin
         skid_cap_ff  <= cap_in;
         skid_code_ff <= res_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            ttwrm_pkg::CSR_SEARCH_TAG: tag_ff    <= csr.data[ttwrm_pkg::TAG_W-1:0];
            ttwrm_pkg::CSR_NOW_HOUR:   hour_ff   <= csr.data[ttwrm_pkg::HOUR_W-1:0];
            ttwrm_pkg::CSR_NOW_MINUTE: minute_ff <= csr.data[ttwrm_pkg::MINUTE_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.capture      = out_cap_ff;
   assign rsp.picture_code = out_code_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tag time-window record matcher testbench
// Streams record tables into the matcher byte by byte, predicts the capture
// verdict of every table from its own model of the matcher, and checks each
// returned verdict in order. Directed tables cover window bounds, wrapping,
// overrides and partial records. Random tables follow under changing
// settings, with random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 450;
   localparam logic [ttwrm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [ttwrm_pkg::TAG_W-1:0] DIR_TAG = 40'h5A_C3_00_FF_81;

   typedef struct packed {
      logic                capture;
      ttwrm_pkg::byte_type picture_code;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttwrm_req_if req_bus ();
   ttwrm_rsp_if rsp_bus ();
   ttwrm_csr_if csr_bus ();

   tag_time_window_record_matcher_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Model state of the matcher.
   logic [ttwrm_pkg::TAG_W-1:0]    want_tag = '0;
   logic [ttwrm_pkg::HOUR_W-1:0]   want_hour = '0;
   logic [ttwrm_pkg::MINUTE_W-1:0] want_minute = '0;
   ttwrm_pkg::byte_type            rec_bytes [ttwrm_pkg::BUF_BYTES];
   int unsigned                    rec_pos = 0;
   logic                           seen_capture = 1'b0;
   ttwrm_pkg::byte_type            kept_code = '0;

   result_type pending_verdicts [$];
   result_type got_verdict;
   int         error_count = 0;
   int         verdicts_checked = 0;
   int         bytes_sent = 0;
   int         cycle_count = 0;
   int         rsp_hold = 0;
   int         rsp_stall = 0;
   bit         calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void absorb_table_byte(ttwrm_pkg::byte_type value, logic last);
      logic [ttwrm_pkg::TAG_W-1:0] rec_tag;
      logic [15:0]                 t_start;
      logic [15:0]                 t_stop;
      logic [15:0]                 t_now;
      logic                        hit;
      result_type                  v;
      if (rec_pos == ttwrm_pkg::BUF_BYTES) begin
         rec_tag = {rec_bytes[0], rec_bytes[1], rec_bytes[2], rec_bytes[3], rec_bytes[4]};
         if (rec_tag == want_tag && value[ttwrm_pkg::FLAG_CAPTURE_BIT]) begin
            t_start = {rec_bytes[ttwrm_pkg::TAG_BYTES], rec_bytes[ttwrm_pkg::TAG_BYTES + 1]};
            t_stop = {rec_bytes[ttwrm_pkg::TAG_BYTES + 2], rec_bytes[ttwrm_pkg::TAG_BYTES + 3]};
            t_now = {3'b000, want_hour, 2'b00, want_minute};
            if (t_stop > t_start) begin
               hit = t_now > t_start && t_now < t_stop;
               if (hit) kept_code = value & ttwrm_pkg::CODE_MASK;
            end else begin
               hit = (t_now < t_stop && t_now < t_start) || (t_now > t_stop && t_now > t_start);
               if (hit) kept_code = value;
            end
            seen_capture = hit;
         end
         rec_pos = 0;
      end else begin
         rec_bytes[rec_pos] = value;
         rec_pos++;
      end
      if (last) begin
         v.capture = seen_capture;
         v.picture_code = seen_capture ? kept_code : 8'h00;
         pending_verdicts.push_back(v);
         rec_pos = 0;
         seen_capture = 1'b0;
         kept_code = '0;
         foreach (rec_bytes[k]) rec_bytes[k] = '0;
      end
   endfunction

   task automatic send_table_byte(ttwrm_pkg::byte_type value, logic last);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.table_byte <= value;
      req_bus.last_byte <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      absorb_table_byte(value, last);
      bytes_sent++;
   endtask

   task automatic send_record(logic [ttwrm_pkg::TAG_W-1:0] tag, logic [15:0] t_start,
                              logic [15:0] t_stop, ttwrm_pkg::byte_type flags, logic last);
      for (int k = ttwrm_pkg::TAG_BYTES - 1; k >= 0; k--) begin
         send_table_byte(tag[8 * k +: 8], 1'b0);
      end
      send_table_byte(t_start[15:8], 1'b0);
      send_table_byte(t_start[7:0], 1'b0);
      send_table_byte(t_stop[15:8], 1'b0);
      send_table_byte(t_stop[7:0], 1'b0);
      send_table_byte(flags, last);
   endtask

   task automatic send_random_record(logic last);
      logic [ttwrm_pkg::TAG_W-1:0] tag;
      logic [15:0]                 now16;
      logic [15:0]                 t_start;
      logic [15:0]                 t_stop;
      ttwrm_pkg::byte_type         flags;
      now16 = {3'b000, want_hour, 2'b00, want_minute};
      case ($urandom_range(0, 9))
         0, 1: tag = {8'($urandom), 32'($urandom)};
         2: tag = want_tag ^ (40'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4)));
         default: tag = want_tag;
      endcase
      case ($urandom_range(0, 3))
         0: begin
            t_start = now16 - 16'($urandom_range(0, 3));
            t_stop = now16 + 16'($urandom_range(0, 3));
         end
         1: begin
            t_start = now16 + 16'($urandom_range(0, 3));
            t_stop = now16 - 16'($urandom_range(0, 3));
         end
         2: begin
            t_start = {8'($urandom_range(0, 23)), 8'($urandom_range(0, 59))};
            t_stop = {8'($urandom_range(0, 23)), 8'($urandom_range(0, 59))};
         end
         default: begin
            t_start = 16'($urandom);
            t_stop = 16'($urandom);
         end
      endcase
      flags = 8'($urandom);
      if ($urandom_range(0, 3) != 0) flags[ttwrm_pkg::FLAG_CAPTURE_BIT] = 1'b1;
      send_record(tag, t_start, t_stop, flags, last);
   endtask

   task automatic send_random_table(int max_records);
      int n_rec;
      int n_tail;
      n_rec = $urandom_range(0, max_records);
      n_tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, ttwrm_pkg::BUF_BYTES) : 0;
      if (n_rec == 0 && n_tail == 0) n_tail = 1;
      for (int r = 0; r < n_rec; r++) send_random_record(r == n_rec - 1 && n_tail == 0);
      for (int k = 0; k < n_tail; k++) send_table_byte(8'($urandom), k == n_tail - 1);
   endtask

   task automatic drain_verdicts();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [ttwrm_pkg::CSR_IDX_W-1:0] index,
                                 logic [ttwrm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (index)
         ttwrm_pkg::CSR_SEARCH_TAG: want_tag = data[ttwrm_pkg::TAG_W-1:0];
         ttwrm_pkg::CSR_NOW_HOUR:   want_hour = data[ttwrm_pkg::HOUR_W-1:0];
         ttwrm_pkg::CSR_NOW_MINUTE: want_minute = data[ttwrm_pkg::MINUTE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic apply_settings(logic [ttwrm_pkg::TAG_W-1:0] tag,
                                 logic [ttwrm_pkg::HOUR_W-1:0] hour,
                                 logic [ttwrm_pkg::MINUTE_W-1:0] minute);
      logic [ttwrm_pkg::CSR_DATA_W-1:0] noise;
      drain_verdicts();
      noise = ($urandom_range(0, 3) == 0) ? {8'($urandom), 32'($urandom)} : '0;
      write_register(ttwrm_pkg::CSR_SEARCH_TAG, ttwrm_pkg::CSR_DATA_W'(tag));
      write_register(ttwrm_pkg::CSR_NOW_HOUR,
                     {noise[ttwrm_pkg::CSR_DATA_W-1:ttwrm_pkg::HOUR_W], hour});
      write_register(ttwrm_pkg::CSR_NOW_MINUTE,
                     {noise[ttwrm_pkg::CSR_DATA_W-1:ttwrm_pkg::MINUTE_W], minute});
      if ($urandom_range(0, 3) == 0) write_register(CSR_UNUSED, {8'($urandom), 32'($urandom)});
   endtask

   task automatic test_reset_settings();
      send_table_byte(8'hFF, 1'b1);
      send_record(40'h0, 16'h0105, 16'h0001, 8'hF3, 1'b1);
   endtask

   task automatic test_forward_window();
      apply_settings(DIR_TAG, 5'd12, 6'd30);
      send_record(DIR_TAG, 16'h0C1D, 16'h0C1F, 8'h3B, 1'b1);
      send_record(DIR_TAG, 16'h0C1D, 16'h0C1F, 8'h3B, 1'b0);
      send_record(DIR_TAG, 16'h0C1E, 16'h0D00, 8'h1F, 1'b1);
      send_record(DIR_TAG, 16'h0B00, 16'h0C1E, 8'h1F, 1'b1);
   endtask

   task automatic test_wrapping_window();
      send_record(DIR_TAG, 16'h0C1E, 16'h0C1E, 8'hD7, 1'b0);
      send_record(DIR_TAG, 16'h0500, 16'h0500, 8'hD7, 1'b1);
      send_record(DIR_TAG, 16'h1000, 16'h0800, 8'h55, 1'b1);
      send_record(DIR_TAG, 16'h2000, 16'h0D00, 8'h30, 1'b1);
   endtask

   task automatic test_record_override();
      send_record(DIR_TAG, 16'h0000, 16'hFFFF, 8'h12, 1'b0);
      send_record(DIR_TAG, 16'h0C00, 16'h0B00, 8'h9A, 1'b0);
      send_record(DIR_TAG ^ 40'h1, 16'h0000, 16'hFFFF, 8'h1F, 1'b0);
      send_record(DIR_TAG, 16'h0000, 16'hFFFF, 8'hEF, 1'b0);
      send_table_byte(8'h00, 1'b1);
   endtask

   task automatic test_partial_record();
      send_record(DIR_TAG, 16'h0C00, 16'h0D00, 8'h1C, 1'b0);
      for (int k = ttwrm_pkg::TAG_BYTES - 1; k >= 0; k--) begin
         send_table_byte(DIR_TAG[8 * k +: 8], 1'b0);
      end
      send_table_byte(8'h0C, 1'b0);
      send_table_byte(8'h1E, 1'b0);
      send_table_byte(8'h0D, 1'b0);
      send_table_byte(8'h00, 1'b1);
   endtask

   task automatic test_extreme_settings();
      apply_settings('1, 5'd31, 6'd63);
      send_record('1, 16'h0000, 16'hFFFF, 8'hFF, 1'b1);
      apply_settings('0, 5'd23, 6'd59);
      send_record('0, 16'hFFFF, 16'h173B, 8'h10, 1'b1);
   endtask

   task automatic test_random_tables();
      logic [ttwrm_pkg::TAG_W-1:0]    tag;
      logic [ttwrm_pkg::HOUR_W-1:0]   hour;
      logic [ttwrm_pkg::MINUTE_W-1:0] minute;
      while (bytes_sent < RANDOM_BYTES || verdicts_checked < 48) begin
         case ($urandom_range(0, 5))
            0: tag = '0;
            1: tag = '1;
            default: tag = {8'($urandom), 32'($urandom)};
         endcase
         case ($urandom_range(0, 7))
            0: hour = 5'd0;
            1: hour = 5'd23;
            2: hour = 5'd31;
            default: hour = 5'($urandom_range(0, 23));
         endcase
         case ($urandom_range(0, 7))
            0: minute = 6'd0;
            1: minute = 6'd59;
            2: minute = 6'd63;
            default: minute = 6'($urandom_range(0, 59));
         endcase
         apply_settings(tag, hour, minute);
         repeat (6) send_random_table(4);
      end
   endtask

   task automatic test_result_backpressure();
      drain_verdicts();
      rsp_hold = 200;
      repeat (3) send_table_byte(8'($urandom), 1'b1);
      repeat (3) send_random_table(1);
      drain_verdicts();
   endtask

   task automatic test_steady_stream();
      int stop_at;
      calm = 1'b1;
      stop_at = bytes_sent + 100;
      while (bytes_sent < stop_at) send_random_table(3);
   endtask

   // Sink of the result channel: random stalls and the long hold-off.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (rsp_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 14);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result: capture %0b picture_code %0h",
                   rsp_bus.capture, rsp_bus.picture_code);
            error_count++;
         end else begin
            got_verdict = pending_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_bus.capture !== got_verdict.capture) begin
               $error("capture: expected %0b, actual %0b", got_verdict.capture,
                      rsp_bus.capture);
               error_count++;
            end
            if (rsp_bus.picture_code !== got_verdict.picture_code) begin
               $error("picture_code: expected %0h, actual %0h", got_verdict.picture_code,
                      rsp_bus.picture_code);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      foreach (rec_bytes[k]) rec_bytes[k] = '0;
      req_bus.valid = 1'b0;
      req_bus.table_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_forward_window();
      test_wrapping_window();
      test_record_override();
      test_partial_record();
      test_extreme_settings();
      test_random_tables();
      test_result_backpressure();
      test_steady_stream();

      drain_verdicts();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
